### rtl/core/nnfd_pkg.sv
// ----------------------------------------------------------------------------
// nnfd_pkg
// shared types, register codes and size helpers for the frame downscaler
// ----------------------------------------------------------------------------
package nnfd_pkg;

  localparam int unsigned SIZE_W  = 13;  // frame size and counter width
  localparam int unsigned WIDE_W  = 14;  // wanted positions and sums
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [SIZE_W-1:0] MAX_FRAME_WIDTH  = 13'd4096;
  localparam logic [SIZE_W-1:0] MAX_FRAME_HEIGHT = 13'd4096;

  // reset sizes and the quotients they give (reset mode is grey8, one pixel a beat)
  localparam logic [SIZE_W-1:0] SRC_W_RST = 13'd640;
  localparam logic [SIZE_W-1:0] SRC_H_RST = 13'd480;
  localparam logic [SIZE_W-1:0] DST_W_RST = 13'd320;
  localparam logic [SIZE_W-1:0] DST_H_RST = 13'd240;
  localparam logic [SIZE_W-1:0] COL_Q_RST = SRC_W_RST / DST_W_RST;
  localparam logic [SIZE_W-1:0] COL_R_RST = SRC_W_RST % DST_W_RST;
  localparam logic [SIZE_W-1:0] ROW_Q_RST = SRC_H_RST / DST_H_RST;
  localparam logic [SIZE_W-1:0] ROW_R_RST = SRC_H_RST % DST_H_RST;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = WIDE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    MODE_GREY8  = 2'd0,
    MODE_RGB565 = 2'd1,
    MODE_RGB24  = 2'd2,
    MODE_YUYV   = 2'd3
  } pix_mode_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_PIXEL_MODE    = 3'd0,
    CFG_SOURCE_WIDTH  = 3'd1,
    CFG_SOURCE_HEIGHT = 3'd2,
    CFG_TARGET_WIDTH  = 3'd3,
    CFG_TARGET_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             line_end;
    logic             frame_end;
  } out_beat_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // yuyv widths lose bit 0 and are at least one pair
  function automatic logic [SIZE_W-1:0] even_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v & ~SIZE_W'(1);
    if (r < SIZE_W'(2)) begin
      r = SIZE_W'(2);
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] pixel_mask(input pix_mode_e m);
    logic [PIX_W-1:0] r;
    unique case (m)
      MODE_GREY8:  r = 32'h0000_00FF;
      MODE_RGB565: r = 32'h0000_FFFF;
      MODE_RGB24:  r = 32'h00FF_FFFF;
      MODE_YUYV:   r = 32'hFFFF_FFFF;
      default:     r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/nnfd_div.sv
// ----------------------------------------------------------------------------
// nnfd_div
// restoring divider for the step quotients, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnfd_div import nnfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WIDE_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [SIZE_W-1:0] quotient_o,
  output logic [SIZE_W-1:0] remainder_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [WIDE_W-1:0]    dvd_q, dvd_d;
  logic [SIZE_W-1:0]    dvs_q, dvs_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W-1:0]    quo_q, quo_d;
  logic [WIDE_W-1:0]    trial;
  logic                 ge;

  assign trial = {rem_q, dvd_q[WIDE_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
      dvd_d  = dvd_q << 1;
      rem_d  = ge ? SIZE_W'(trial - {1'b0, dvs_q}) : trial[SIZE_W-1:0];
      quo_d  = {quo_q[SIZE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o      = (cnt_q != '0) || done_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### rtl/core/nearest_neighbour_frame_downscaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_frame_downscaler
// streaming nearest-neighbour downscaler for raster-order frames
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid/in_ready   | in_beat_t: pixel_in, frame_start
//  out     | source    | out_valid/out_ready | out_beat_t: pixel_out, line_end,
//          |           |                     |   frame_end
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
//  one source beat a cycle; each beat updates the counters in a single pass
//  and loads at most one beat into the output register
//  the output register frees in the cycle it is taken, so a stalled sink
//  holds the source only while its result is unclaimed
//  a register write recomputes the column and row step quotients in two
//  restoring dividers: the source stalls after the write until both are done
//  reset gives 640x480 to 320x240 grey8 with its quotients preloaded
//
module nearest_neighbour_frame_downscaler import nnfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_beat_t        out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // register file as written
  // --------------------------------------------------------------------------
  pix_mode_e         mode_q;
  logic [SIZE_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic              cfg_fire;
  logic              pend_q;

  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_GREY8;
      src_w_q <= SRC_W_RST;
      src_h_q <= SRC_H_RST;
      dst_w_q <= DST_W_RST;
      dst_h_q <= DST_H_RST;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_PIXEL_MODE:    mode_q  <= pix_mode_e'(cfg_data_i[1:0]);
          CFG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
          CFG_SOURCE_HEIGHT: src_h_q <= cfg_data_i;
          CFG_TARGET_WIDTH:  dst_w_q <= cfg_data_i;
          CFG_TARGET_HEIGHT: dst_h_q <= cfg_data_i;
          default: ;  // unused index, nothing to write
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // effective sizes: clamp, even widths for yuyv, target never above source
  // --------------------------------------------------------------------------
  logic              yuyv_c;
  logic [SIZE_W-1:0] sw_c, sh_c, dw_c, dh_c, sw_lim, dw_lim;

  always_comb begin
    yuyv_c = (mode_q == MODE_YUYV);
    sw_lim = clamp_size(src_w_q, MAX_FRAME_WIDTH);
    dw_lim = clamp_size(dst_w_q, MAX_FRAME_WIDTH);
    sh_c   = clamp_size(src_h_q, MAX_FRAME_HEIGHT);
    dh_c   = clamp_size(dst_h_q, MAX_FRAME_HEIGHT);
    if (yuyv_c) begin
      sw_lim = even_size(sw_lim);
      dw_lim = even_size(dw_lim);
    end
    sw_c = sw_lim;
    dw_c = (dw_lim > sw_lim) ? sw_lim : dw_lim;
    if (dh_c > sh_c) begin
      dh_c = sh_c;
    end
  end

  // sizes used by the pixel path, latched as the dividers start
  pix_mode_e         emode_q;
  logic [SIZE_W-1:0] sw_q, sh_q, dw_q, dh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emode_q <= MODE_GREY8;
      sw_q    <= SRC_W_RST;
      sh_q    <= SRC_H_RST;
      dw_q    <= DST_W_RST;
      dh_q    <= DST_H_RST;
    end else if (pend_q) begin
      emode_q <= mode_q;
      sw_q    <= sw_c;
      sh_q    <= sh_c;
      dw_q    <= dw_c;
      dh_q    <= dh_c;
    end
  end

  // --------------------------------------------------------------------------
  // step quotients: columns k*sw/dw, rows sh/dh
  // --------------------------------------------------------------------------
  logic              col_busy, col_done, row_busy, row_done;
  logic [SIZE_W-1:0] col_quo, col_rem, row_quo, row_rem;
  logic [WIDE_W-1:0] col_dividend;
  logic [SIZE_W-1:0] col_q_q, col_r_q, row_q_q, row_r_q;

  assign col_dividend = yuyv_c ? {sw_c, 1'b0} : {1'b0, sw_c};

  nnfd_div u_col_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (pend_q),
    .dividend_i  (col_dividend),
    .divisor_i   (dw_c),
    .busy_o      (col_busy),
    .done_o      (col_done),
    .quotient_o  (col_quo),
    .remainder_o (col_rem)
  );

  nnfd_div u_row_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (pend_q),
    .dividend_i  ({1'b0, sh_c}),
    .divisor_i   (dh_c),
    .busy_o      (row_busy),
    .done_o      (row_done),
    .quotient_o  (row_quo),
    .remainder_o (row_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q_q <= COL_Q_RST;
      col_r_q <= COL_R_RST;
      row_q_q <= ROW_Q_RST;
      row_r_q <= ROW_R_RST;
    end else begin
      if (col_done) begin
        col_q_q <= col_quo;
        col_r_q <= col_rem;
      end
      if (row_done) begin
        row_q_q <= row_quo;
        row_r_q <= row_rem;
      end
    end
  end

  logic cfg_busy;
  assign cfg_busy    = pend_q || col_busy || row_busy;
  assign cfg_ready_o = !cfg_busy;

  // --------------------------------------------------------------------------
  // selection counters
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
  logic [SIZE_W-1:0] src_col_d, src_row_d, dst_col_d, dst_row_d;
  logic [WIDE_W-1:0] wcol_q, wrow_q, wcol_d, wrow_d;
  logic [SIZE_W-1:0] crem_q, rrem_q, crem_d, rrem_d;

  logic [SIZE_W-1:0] c_src_col, c_src_row, c_dst_col, c_dst_row, c_crem, c_rrem;
  logic [WIDE_W-1:0] c_wcol, c_wrow;
  logic              yuyv, row_sel, col_match, emit, le, fe;
  logic [WIDE_W-1:0] k, src_sum, row_inc, crem_sum, rrem_sum;
  logic              crem_ge, rrem_ge;
  logic [PIX_W-1:0]  pix;
  logic              in_fire, out_valid_q, out_valid_d;
  out_beat_t         out_q;

  assign in_ready_o = !cfg_busy && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    yuyv = (emode_q == MODE_YUYV);
    k    = yuyv ? WIDE_W'(2) : WIDE_W'(1);

    // frame start clears everything before this beat is used
    c_src_col = in_i.frame_start ? '0 : src_col_q;
    c_src_row = in_i.frame_start ? '0 : src_row_q;
    c_dst_col = in_i.frame_start ? '0 : dst_col_q;
    c_dst_row = in_i.frame_start ? '0 : dst_row_q;
    c_wcol    = in_i.frame_start ? '0 : wcol_q;
    c_wrow    = in_i.frame_start ? '0 : wrow_q;
    c_crem    = in_i.frame_start ? '0 : crem_q;
    c_rrem    = in_i.frame_start ? '0 : rrem_q;

    row_sel   = ({1'b0, c_src_row} == c_wrow) && (c_dst_row < dh_q);
    // yuyv matches on the pair holding the wanted pixel
    col_match = yuyv ? ({1'b0, c_src_col[SIZE_W-1:1]} == c_wcol[WIDE_W-1:1])
                     : ({1'b0, c_src_col} == c_wcol);
    emit      = row_sel && (c_dst_col < dw_q) && col_match;
    le        = ({1'b0, c_dst_col} + k) >= {1'b0, dw_q};
    fe        = le && (({1'b0, c_dst_row} + WIDE_W'(1)) >= {1'b0, dh_q});

    pix = in_i.pixel_in & pixel_mask(emode_q);
    if (yuyv && c_wcol[0]) begin
      pix[7:0] = pix[23:16];  // odd wanted column: y1 stands in for y0
    end

    // column step
    crem_sum = {1'b0, c_crem} + {1'b0, col_r_q};
    crem_ge  = crem_sum >= {1'b0, dw_q};
    src_col_d = c_src_col;
    dst_col_d = c_dst_col;
    wcol_d    = c_wcol;
    crem_d    = c_crem;
    if (emit) begin
      dst_col_d = SIZE_W'({1'b0, c_dst_col} + k);
      wcol_d    = c_wcol + {1'b0, col_q_q} + WIDE_W'(crem_ge);
      crem_d    = crem_ge ? SIZE_W'(crem_sum - {1'b0, dw_q}) : crem_sum[SIZE_W-1:0];
    end

    // row step
    rrem_sum  = {1'b0, c_rrem} + {1'b0, row_r_q};
    rrem_ge   = rrem_sum >= {1'b0, dh_q};
    row_inc   = {1'b0, c_src_row} + WIDE_W'(1);
    src_row_d = c_src_row;
    dst_row_d = c_dst_row;
    wrow_d    = c_wrow;
    rrem_d    = c_rrem;

    src_sum = {1'b0, c_src_col} + k;
    if (src_sum >= {1'b0, sw_q}) begin
      // end of source line
      src_col_d = '0;
      dst_col_d = '0;
      wcol_d    = '0;
      crem_d    = '0;
      if (row_sel) begin
        dst_row_d = c_dst_row + SIZE_W'(1);
        wrow_d    = c_wrow + {1'b0, row_q_q} + WIDE_W'(rrem_ge);
        rrem_d    = rrem_ge ? SIZE_W'(rrem_sum - {1'b0, dh_q}) : rrem_sum[SIZE_W-1:0];
      end
      if (row_inc >= {1'b0, sh_q}) begin
        // end of source frame wraps to a fresh frame
        src_row_d = '0;
        dst_row_d = '0;
        wrow_d    = '0;
        rrem_d    = '0;
      end else begin
        src_row_d = row_inc[SIZE_W-1:0];
      end
    end else begin
      src_col_d = src_sum[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      wcol_q    <= '0;
      wrow_q    <= '0;
      crem_q    <= '0;
      rrem_q    <= '0;
    end else if (in_fire) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      wcol_q    <= wcol_d;
      wrow_q    <= wrow_d;
      crem_q    <= crem_d;
      rrem_q    <= rrem_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_q.pixel_out <= pix;
      out_q.line_end  <= le;
      out_q.frame_end <= fe;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cfg_stalls_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> !in_ready_o)
    else $error("source taken straight after a register write");

  a_dividers_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_busy == row_busy) && (col_done == row_done))
    else $error("column and row dividers out of step");

  a_no_beat_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_busy |-> !in_fire)
    else $error("source beat taken while quotients are stale");

  a_frame_end_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_o.frame_end || out_o.line_end))
    else $error("frame end without line end");

endmodule
